// ===== design/htc_pkg.sv =====
// Shared types, constants and a helper function for the heading turn controller.
package htc_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 12;
    localparam int DRIVE_FRAC_BITS_DEF = 14;

    localparam int ANGLE_W     = 15;
    localparam int MARGIN_W    = 14;
    localparam int DRIVE_W     = 15;
    localparam int CFG_W       = 15;
    localparam int CFG_IDX_W   = 1;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 1'b1;

    localparam logic [ANGLE_W-1:0]  TARGET_RESET = 15'd0;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = 14'd41;

    localparam int GAIN_P = 10;
    localparam int GAIN_D = 110;

    // pi in Q.30; pi_fixed reduces it to the angle format with round to nearest
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    function automatic logic [31:0] pi_fixed(input int frac_bits);
        logic [63:0] r;
        r = (PI_Q30 + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
        return r[31:0];
    endfunction

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRAP,
        ST_PREP,
        ST_CALC,
        ST_DSTART,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } htc_state_t;

    typedef enum logic [1:0] {
        RES_DONE,
        RES_PRIME,
        RES_DRIVE
    } htc_result_t;

    typedef struct packed {
        logic        capture;
        logic        wrap_en;
        logic        prep_en;
        logic        calc_en;
        logic        div_start;
        logic        sum_en;
        logic        load_out;
        htc_result_t kind;
    } htc_cmd_t;

    typedef struct packed {
        logic in_margin;
        logic primed;
        logic div_done;
        logic out_free;
    } htc_status_t;

endpackage

// ===== design/htc_divider.sv =====
// Restoring divider, one quotient bit per cycle, for the saturating heading term.
module htc_divider #(
    parameter int NW   = 36,
    parameter int DV_W = 18,
    parameter int QW   = 18
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NW-1:0]   dividend,
    input  logic [DV_W-1:0] divisor,
    output logic [QW-1:0]   quotient,
    output logic            done
);
    localparam int CNT_W = $clog2(QW);

    logic [NW-1:0]    rem_reg;
    logic [NW-1:0]    dsh_reg;
    logic [QW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             fits;

    assign fits = (rem_reg >= dsh_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsh_reg <= NW'(divisor) << (QW - 1);
            q_reg   <= '0;
            cnt_reg <= CNT_W'(QW - 1);
        end else if (busy_reg) begin
            if (fits) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[QW-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    assign quotient = q_reg;
    assign done     = done_reg;

endmodule

// ===== design/htc_datapath.sv =====
// Datapath: config registers, angle wrap, PD terms, divider and result register.
module htc_datapath #(
    parameter int ANGLE_FRAC_BITS = htc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int DRIVE_FRAC_BITS = htc_pkg::DRIVE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [htc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic [htc_pkg::ANGLE_W-1:0]   sample_in,
    input  logic                          m_tready,
    input  htc_pkg::htc_cmd_t             cmd,
    output htc_pkg::htc_status_t          status,
    output logic                          m_tvalid,
    output logic [htc_pkg::DRIVE_W-1:0]   left_drive,
    output logic [htc_pkg::DRIVE_W-1:0]   right_drive,
    output logic                          done_res
);
    import htc_pkg::*;

    localparam int F     = ANGLE_FRAC_BITS;
    localparam int D     = DRIVE_FRAC_BITS;
    localparam int E_W   = ANGLE_W + 1;
    localparam int AE_W  = ANGLE_W + 1;
    localparam int AD_W  = AE_W + 1;
    localparam int DEN_W = AE_W + 1;
    localparam int DV_W  = AE_W + 2;
    localparam int NW    = AE_W + D + 6;
    localparam int QW    = D + 4;
    localparam int P_W   = AD_W + 7;
    localparam int T_W   = P_W + D + 1;
    localparam int S_W   = T_W + 2;

    localparam logic signed [31:0]    PI_S       = signed'(pi_fixed(F));
    localparam logic signed [31:0]    TWO_PI_S   = PI_S <<< 1;
    localparam logic [DEN_W-1:0]      HALF_ANGLE = DEN_W'(1) << (F - 1);
    localparam logic [T_W-1:0]        T2_HALF    = T_W'(1) << (F - 1);
    localparam logic signed [S_W-1:0] LIM_POS    = S_W'(1) << (D - 1);
    localparam logic signed [S_W-1:0] LIM_NEG    = -LIM_POS;

    logic [ANGLE_W-1:0]      target_reg;
    logic [MARGIN_W-1:0]     margin_reg;
    logic [ANGLE_W-1:0]      sample_reg;
    logic signed [E_W-1:0]   e_reg;
    logic signed [E_W-1:0]   prev_reg;
    logic                    primed_reg;
    logic [AE_W-1:0]         ae_reg;
    logic                    in_margin_reg;
    logic                    e_neg_reg;
    logic [AD_W-1:0]         ad_reg;
    logic                    d_neg_reg;
    logic [NW-1:0]           num2_reg;
    logic [DV_W-1:0]         dv_reg;
    logic [P_W-1:0]          p_reg;
    logic [T_W-1:0]          t2_reg;
    logic signed [S_W-1:0]   u_reg;
    logic                    out_valid_reg;
    logic [DRIVE_W-1:0]      left_reg;
    logic [DRIVE_W-1:0]      right_reg;
    logic                    done_reg;

    logic signed [31:0]      diff_w;
    logic signed [31:0]      wrap_w;
    logic signed [E_W-1:0]   e_next;
    logic [AE_W-1:0]         ae_next;
    logic                    in_margin_next;
    logic signed [AD_W-1:0]  dd;
    logic [AD_W-1:0]         ad_next;
    logic [DEN_W-1:0]        den;
    logic [NW-1:0]           num2_next;
    logic [DV_W-1:0]         dv_next;
    logic [P_W-1:0]          p_next;
    logic [T_W-1:0]          t2_next;
    logic [QW-1:0]           quotient;
    logic                    div_done;
    logic signed [S_W-1:0]   t1s;
    logic signed [S_W-1:0]   t2s;
    logic signed [S_W-1:0]   sum;
    logic signed [S_W-1:0]   u_next;
    logic signed [S_W-1:0]   u_neg;

    // Error to target, wrapped once by 2pi
    always_comb begin
        diff_w = signed'(32'(target_reg)) - signed'(32'(sample_reg));
        if (diff_w > PI_S) begin
            wrap_w = diff_w - TWO_PI_S;
        end else if (diff_w < -PI_S) begin
            wrap_w = diff_w + TWO_PI_S;
        end else begin
            wrap_w = diff_w;
        end
        e_next = wrap_w[E_W-1:0];
    end

    // Magnitudes and signs
    always_comb begin
        ae_next        = e_reg[E_W-1] ? unsigned'(-e_reg) : unsigned'(e_reg);
        in_margin_next = (ae_next <= AE_W'(margin_reg));
        dd             = AD_W'(e_reg) - AD_W'(prev_reg);
        ad_next        = dd[AD_W-1] ? unsigned'(-dd) : unsigned'(dd);
    end

    // Dividend 2*num + den and divisor 2*den of the rounded quotient
    always_comb begin
        den       = DEN_W'(ae_reg) + HALF_ANGLE;
        num2_next = ((NW'(ae_reg) * NW'(GAIN_P)) << (D + 1)) + NW'(den);
        dv_next   = {den, 1'b0};
        p_next    = P_W'(ad_reg) * P_W'(GAIN_D);
        t2_next   = ((T_W'(p_reg) << D) + T2_HALF) >> F;
    end

    always_comb begin
        t1s   = signed'(S_W'(quotient));
        t2s   = signed'(S_W'(t2_reg));
        sum   = (e_neg_reg ? -t1s : t1s) + (d_neg_reg ? -t2s : t2s);
        if (sum > LIM_POS) begin
            u_next = LIM_POS;
        end else if (sum < LIM_NEG) begin
            u_next = LIM_NEG;
        end else begin
            u_next = sum;
        end
        u_neg = -u_reg;
    end

    htc_divider #(
        .NW   (NW),
        .DV_W (DV_W),
        .QW   (QW)
    ) u_htc_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (num2_reg),
        .divisor  (dv_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RESET;
            margin_reg <= MARGIN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_TARGET: target_reg <= cfg_wdata[ANGLE_W-1:0];
                REG_MARGIN: margin_reg <= cfg_wdata[MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            sample_reg <= sample_in;
        end
        if (cmd.wrap_en) begin
            e_reg <= e_next;
        end
        if (cmd.prep_en) begin
            ae_reg        <= ae_next;
            in_margin_reg <= in_margin_next;
            e_neg_reg     <= e_reg[E_W-1];
            ad_reg        <= ad_next;
            d_neg_reg     <= dd[AD_W-1];
        end
        if (cmd.calc_en) begin
            num2_reg <= num2_next;
            dv_reg   <= dv_next;
            p_reg    <= p_next;
        end
        if (cmd.div_start) begin
            t2_reg <= t2_next;
        end
        if (cmd.sum_en) begin
            u_reg <= u_next;
        end
    end

    // Stored error and priming flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg   <= '0;
            primed_reg <= 1'b0;
        end else if (cmd.load_out) begin
            case (cmd.kind)
                RES_DONE: primed_reg <= 1'b0;
                RES_PRIME: begin
                    prev_reg   <= e_reg;
                    primed_reg <= 1'b1;
                end
                RES_DRIVE: prev_reg <= e_reg;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            case (cmd.kind)
                RES_DONE: begin
                    left_reg  <= '0;
                    right_reg <= '0;
                    done_reg  <= 1'b1;
                end
                RES_DRIVE: begin
                    left_reg  <= u_reg[DRIVE_W-1:0];
                    right_reg <= u_neg[DRIVE_W-1:0];
                    done_reg  <= 1'b0;
                end
                default: begin
                    left_reg  <= '0;
                    right_reg <= '0;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    assign status.in_margin = in_margin_reg;
    assign status.primed    = primed_reg;
    assign status.div_done  = div_done;
    assign status.out_free  = !out_valid_reg || m_tready;

    assign m_tvalid    = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign done_res    = done_reg;

endmodule

// ===== design/htc_ctrl.sv =====
// Controller state machine that sequences the datapath for one sample.
module htc_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  htc_pkg::htc_status_t status,
    output htc_pkg::htc_cmd_t    cmd
);
    import htc_pkg::*;

    htc_state_t  state_reg;
    htc_state_t  state_next;
    htc_result_t kind_reg;
    htc_result_t kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            kind_reg  <= RES_DONE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: state_next = ST_PREP;
            ST_PREP: state_next = ST_CALC;
            ST_CALC: begin
                if (status.in_margin) begin
                    kind_next  = RES_DONE;
                    state_next = ST_OUT;
                end else if (!status.primed) begin
                    kind_next  = RES_PRIME;
                    state_next = ST_OUT;
                end else begin
                    kind_next  = RES_DRIVE;
                    state_next = ST_DSTART;
                end
            end
            ST_DSTART: state_next = ST_DIV;
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: state_next = ST_OUT;
            ST_OUT: begin
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.kind = kind_reg;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_WRAP:   cmd.wrap_en   = 1'b1;
            ST_PREP:   cmd.prep_en   = 1'b1;
            ST_CALC:   cmd.calc_en   = 1'b1;
            ST_DSTART: cmd.div_start = 1'b1;
            ST_SUM:    cmd.sum_en    = 1'b1;
            ST_OUT:    cmd.load_out  = status.out_free;
            default: ;
        endcase
    end

endmodule

// ===== design/heading_turn_controller.sv =====
// Top level of the PD heading controller with angle wrap.
//
// One heading sample (radians, Q.ANGLE_FRAC_BITS, unsigned) comes in per
// transaction on the s_ side and yields exactly one result transaction on the
// m_ side. The error to target_heading is wrapped once by 2pi. If |error| is
// within margin the result carries done (tuser = 1) with zero drives and the
// controller re-arms; the next sample outside the margin only primes the
// stored error and returns zero drives. Every later sample returns the drive
// 10*e/(0.5+|e|) + 110*(e - e_prev) clamped to +/-0.5 in Q.DRIVE_FRAC_BITS on
// the left and its negation on the right. One sample is processed at a time:
// a done or priming sample passes through the wrap, prep and calc states to the
// output register, and ready rises again in the same cycle the result turns
// valid; a drive sample also passes through the restoring divider, which
// produces one quotient bit per cycle for the saturating term, and the sum.
// The result waits in an output register; the block returns to ready as soon
// as that register can take the next result. Configuration is written through
// cfg_we / cfg_index / cfg_wdata and takes effect at once; write it only while
// no sample is in flight.
module heading_turn_controller #(
    parameter int ANGLE_FRAC_BITS = htc_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int DRIVE_FRAC_BITS = htc_pkg::DRIVE_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Register write port: index 0 target_heading, index 1 margin
    input  logic                          cfg_we,
    input  logic [htc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [htc_pkg::CFG_W-1:0]     cfg_wdata,
    // Sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [htc_pkg::S_TDATA_W-1:0] s_tdata,   // [14:0] heading_sample, [15] zero
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [htc_pkg::M_TDATA_W-1:0] m_tdata,   // [14:0] left_drive, [29:15] right_drive,
                                                     // [31:30] zero
    output logic                          m_tuser    // [0] done_res
);
    import htc_pkg::*;

    htc_cmd_t           cmd;
    htc_status_t        status;
    logic [DRIVE_W-1:0] left_drive;
    logic [DRIVE_W-1:0] right_drive;

    // Sequencing: one sample at a time through wrap, prep, calc, divide, sum
    htc_ctrl u_htc_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Arithmetic, state and the output register
    htc_datapath #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .DRIVE_FRAC_BITS (DRIVE_FRAC_BITS)
    ) u_htc_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .sample_in   (s_tdata[ANGLE_W-1:0]),
        .m_tready    (m_tready),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .left_drive  (left_drive),
        .right_drive (right_drive),
        .done_res    (m_tuser)
    );

    // Pack the drives, pad to whole bytes
    assign m_tdata = {{(M_TDATA_W - 2 * DRIVE_W){1'b0}}, right_drive, left_drive};

endmodule

// ===== design/htc_checker.sv =====
// Port-level checks on the heading turn controller, bound to the top level.
module htc_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [htc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                          m_tuser
);
    import htc_pkg::*;

    // Right drive always mirrors the left drive
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[DRIVE_W-1:0] + m_tdata[2*DRIVE_W-1:DRIVE_W]) == 15'd0))
        else $error("right drive is not the negation of left drive");

    // A done result carries no drive
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata == '0))
        else $error("done result with nonzero drive");

    // One sample at a time: ready drops after each accepted sample
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second sample accepted while one is in flight");

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind heading_turn_controller htc_checker u_htc_checker (.*);

// ===== sim/heading_turn_controller_test.sv =====
// Self-checking testbench for the heading turn controller: directed table, then random sweeps.
`timescale 1ns / 1ps

module heading_turn_controller_test;

    import htc_pkg::*;

    localparam int AF = ANGLE_FRAC_BITS_DEF;
    localparam int DF = DRIVE_FRAC_BITS_DEF;
    localparam longint PI_FIX = longint'((PI_Q30 + (64'd1 << (29 - AF))) >> (30 - AF));
    localparam longint TWO_PI_FIX = 2 * PI_FIX;
    localparam longint HALF_RAD = longint'(1) << (AF - 1);
    localparam longint DRIVE_CLAMP = longint'(1) << (DF - 1);
    // Leave slack after the drive path before touching the registers.
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int IDLE_PCT = 11;
    localparam int PHASES = 9;
    localparam int ITEMS_PER_PHASE = 150;

    // One result transaction as the block reports it.
    typedef struct packed {
        logic [DRIVE_W-1:0] left;
        logic [DRIVE_W-1:0] right;
        logic               done;
    } steer_cmd_t;

    typedef enum logic [1:0] {
        ROW_TARGET,
        ROW_MARGIN,
        ROW_SAMPLE
    } row_kind_t;

    typedef struct packed {
        row_kind_t      kind;
        logic [14:0]    value;
        logic           fixed;   // 1: compare against want, else against the predictor
        steer_cmd_t     want;
    } row_t;

    localparam logic [DRIVE_W-1:0] DRIVE_POS = 15'd8192;
    localparam logic [DRIVE_W-1:0] DRIVE_NEG = 15'(-8192);
    localparam steer_cmd_t AT_TARGET  = '{15'd0, 15'd0, 1'b1};
    localparam steer_cmd_t PRIMING    = '{15'd0, 15'd0, 1'b0};
    localparam steer_cmd_t FULL_LEFT  = '{DRIVE_POS, DRIVE_NEG, 1'b0};
    localparam steer_cmd_t FULL_RIGHT = '{DRIVE_NEG, DRIVE_POS, 1'b0};
    localparam steer_cmd_t PREDICTED  = '{15'd0, 15'd0, 1'b0};

    // Directed stimulus. Starts from reset: target 0, margin 41.
    localparam int DIR_ROWS = 29;
    row_t dir_rows [DIR_ROWS] = '{
        '{ROW_SAMPLE, 15'd0,     1'b1, AT_TARGET},   // zero error
        '{ROW_SAMPLE, 15'd41,    1'b1, AT_TARGET},   // error exactly at margin
        '{ROW_SAMPLE, 15'd42,    1'b1, PRIMING},     // one past margin: prime only
        '{ROW_SAMPLE, 15'd25735, 1'b1, AT_TARGET},   // wraps to +1
        '{ROW_SAMPLE, 15'd12868, 1'b1, PRIMING},     // error of exactly -pi, no wrap
        '{ROW_SAMPLE, 15'd12869, 1'b1, FULL_LEFT},   // wraps to just under +pi
        '{ROW_SAMPLE, 15'd32767, 1'b1, FULL_RIGHT},  // out-of-range heading
        '{ROW_MARGIN, 15'd0,     1'b0, PREDICTED},
        '{ROW_SAMPLE, 15'd0,     1'b1, AT_TARGET},
        '{ROW_SAMPLE, 15'd1,     1'b1, PRIMING},
        '{ROW_SAMPLE, 15'd2,     1'b0, PREDICTED},   // unclamped drive
        '{ROW_SAMPLE, 15'd3,     1'b0, PREDICTED},
        '{ROW_SAMPLE, 15'd1,     1'b0, PREDICTED},   // derivative reverses
        '{ROW_TARGET, 15'd25735, 1'b0, PREDICTED},
        '{ROW_MARGIN, 15'd12867, 1'b0, PREDICTED},
        '{ROW_SAMPLE, 15'd0,     1'b1, AT_TARGET},
        '{ROW_SAMPLE, 15'd12867, 1'b1, PRIMING},     // error of exactly +pi
        '{ROW_MARGIN, 15'h7fff,  1'b0, PREDICTED},   // upper bit dropped
        '{ROW_SAMPLE, 15'd32767, 1'b1, AT_TARGET},
        '{ROW_TARGET, 15'h7fff,  1'b0, PREDICTED},   // out-of-range target
        '{ROW_MARGIN, 15'h4000,  1'b0, PREDICTED},   // masks to zero
        '{ROW_SAMPLE, 15'd0,     1'b1, PRIMING},
        '{ROW_SAMPLE, 15'd0,     1'b1, FULL_LEFT},
        '{ROW_SAMPLE, 15'd32767, 1'b1, AT_TARGET},
        '{ROW_TARGET, 15'd0,     1'b0, PREDICTED},
        '{ROW_MARGIN, 15'd41,    1'b0, PREDICTED},
        '{ROW_SAMPLE, 15'd100,   1'b1, PRIMING},
        '{ROW_SAMPLE, 15'd90,    1'b0, PREDICTED},
        '{ROW_SAMPLE, 15'd95,    1'b0, PREDICTED}
    };

    // Block ports; every input holds a known value from time zero.
    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_TARGET;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;     // [14:0] heading_sample, [15] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;          // [14:0] left_drive, [29:15] right_drive
    logic                  m_tuser;          // [0] done_res

    // Predictor copy of the registers and the controller state.
    logic [ANGLE_W-1:0]    tgt_heading = TARGET_RESET;
    logic [MARGIN_W-1:0]   err_margin = MARGIN_RESET;
    longint                last_err = 0;
    bit                    armed = 1'b0;

    steer_cmd_t            expected_cmds [$];
    int                    mismatches = 0;
    int                    cycle_count = 0;
    bit                    calm = 1'b0;     // suppress idling on both sides

    heading_turn_controller dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Work out the command the controller owes for one heading sample and
    // advance the predictor state the same way the block does.
    function automatic steer_cmd_t predict_steer(input logic [ANGLE_W-1:0] heading);
        longint err, mag_e, delta, mag_d, sat_term, rate_term, drive, neg_drive;
        longint num, den;
        steer_cmd_t cmd;
        err = longint'(tgt_heading) - longint'(heading);
        if (err > PI_FIX)
            err -= TWO_PI_FIX;
        else if (err < -PI_FIX)
            err += TWO_PI_FIX;
        mag_e = (err < 0) ? -err : err;
        drive = 0;
        cmd.done = 1'b0;
        if (mag_e <= longint'(err_margin)) begin
            // Within margin: stop and re-arm, keep the stored error.
            cmd.done = 1'b1;
            armed = 1'b0;
        end else if (!armed) begin
            last_err = err;
            armed = 1'b1;
        end else begin
            // Saturating term 10*e/(0.5+|e|), rounded half away from zero.
            num = (longint'(GAIN_P) * mag_e) << DF;
            den = HALF_RAD + mag_e;
            sat_term = (2 * num + den) / (2 * den);
            if (err < 0)
                sat_term = -sat_term;
            // Derivative term 110*(e - e_prev).
            delta = err - last_err;
            mag_d = (delta < 0) ? -delta : delta;
            rate_term = (((longint'(GAIN_D) * mag_d) << DF) + HALF_RAD) >> AF;
            if (delta < 0)
                rate_term = -rate_term;
            drive = sat_term + rate_term;
            if (drive > DRIVE_CLAMP)
                drive = DRIVE_CLAMP;
            if (drive < -DRIVE_CLAMP)
                drive = -DRIVE_CLAMP;
            last_err = err;
        end
        neg_drive = -drive;
        cmd.left = drive[DRIVE_W-1:0];
        cmd.right = neg_drive[DRIVE_W-1:0];
        return cmd;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Drop valid and hold until every outstanding command has come back,
    // then let the datapath settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Registers change only with the block idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_TARGET)
            tgt_heading = val[ANGLE_W-1:0];
        else
            err_margin = val[MARGIN_W-1:0];
    endtask

    // Offer one heading sample; predict its command once the transaction is taken.
    task automatic push_sample(input logic [ANGLE_W-1:0] heading, input bit fixed,
                               input steer_cmd_t want);
        steer_cmd_t cmd;
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {1'b0, heading};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        cmd = predict_steer(heading);
        expected_cmds.push_back(fixed ? want : cmd);
    endtask

    // Result side: check each transaction against the oldest expectation and
    // stall at random.
    always @(posedge aclk) begin
        steer_cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_cmds.size() == 0) begin
                report_mismatch("result with nothing outstanding", int'(m_tdata), 0);
            end else begin
                want = expected_cmds.pop_front();
                if (m_tdata[14:0] !== want.left)
                    report_mismatch("left_drive", $signed(m_tdata[14:0]), $signed(want.left));
                if (m_tdata[29:15] !== want.right)
                    report_mismatch("right_drive", $signed(m_tdata[29:15]),
                                    $signed(want.right));
                if (m_tuser !== want.done)
                    report_mismatch("done_res", int'(m_tuser), int'(want.done));
            end
        end
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: end a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int sample, err_pick, walk, roll, wrap_pick;
        logic [CFG_W-1:0] tgt_val, margin_val;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed table.
        foreach (dir_rows[i]) begin
            case (dir_rows[i].kind)
                ROW_TARGET: write_reg(REG_TARGET, dir_rows[i].value);
                ROW_MARGIN: write_reg(REG_MARGIN, dir_rows[i].value);
                default: push_sample(dir_rows[i].value, dir_rows[i].fixed, dir_rows[i].want);
            endcase
        end

        // Random sweeps, one register setting per phase. Phase 0 runs without
        // idling on either side.
        for (int phase = 0; phase < PHASES; phase++) begin
            calm = (phase == 0);
            case (phase % 4)
                0: tgt_val = 15'd0;
                1: tgt_val = 15'd25735;
                2: tgt_val = 15'($urandom_range(25735));
                default: tgt_val = 15'($urandom_range(32767));
            endcase
            case (phase % 5)
                0: margin_val = 15'($urandom_range(60));
                1: margin_val = 15'd0;
                2: margin_val = 15'($urandom_range(32767));   // upper bit masked off
                3: margin_val = 15'd12867;
                default: margin_val = 15'($urandom_range(120));
            endcase
            write_reg(REG_TARGET, tgt_val);
            write_reg(REG_MARGIN, margin_val);
            walk = int'($urandom_range(200)) - 100;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold off the sender once mid-run until all results are back.
                if (phase == 4 && n == ITEMS_PER_PHASE / 2)
                    drain_results();
                roll = $urandom_range(99);
                if (roll < 60) begin
                    // Slow walk around the target: unclamped drive lives here.
                    if ($urandom_range(99) < 5)
                        walk = int'($urandom_range(2 * (err_margin + 150)))
                               - int'(err_margin) - 150;
                    else
                        walk += int'($urandom_range(16)) - 8;
                    if (walk > 3000)
                        walk = 3000;
                    if (walk < -3000)
                        walk = -3000;
                    err_pick = walk;
                end else if (roll < 72) begin
                    // Hug the margin edge.
                    err_pick = int'(err_margin) + int'($urandom_range(2)) - 1;
                    if ($urandom_range(1))
                        err_pick = -err_pick;
                end else if (roll < 82) begin
                    // Hug the wrap point at +/-pi.
                    wrap_pick = int'(PI_FIX) + int'($urandom_range(2)) - 1;
                    err_pick = $urandom_range(1) ? wrap_pick : -wrap_pick;
                end else begin
                    err_pick = 0;
                end
                if (roll < 82) begin
                    sample = int'(tgt_val[ANGLE_W-1:0]) - err_pick;
                    while (sample < 0)
                        sample += int'(TWO_PI_FIX);
                    while (sample > 32767)
                        sample -= int'(TWO_PI_FIX);
                end else begin
                    sample = int'($urandom_range(32767));
                end
                push_sample(15'(sample), 1'b0, PREDICTED);
            end
        end

        calm = 1'b0;
        drain_results();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
